FILE: rtl/imu_complementary_attitude_filter_unit_macros.svh
// Assertion macros for the attitude filter.
`ifndef IMU_COMPLEMENTARY_ATTITUDE_FILTER_UNIT_MACROS_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define IMU_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("failed");
`define IMU_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("failed");
`else
`define IMU_ASSERT_IMPL(label, clk, rst, a, c)
`define IMU_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

FILE: rtl/imu_caf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attitude filter package
// Shared types, constants, the arctangent table and a saturation helper.
// ----------------------------------------------------------------------------
package imu_caf_pkg;
  localparam int CordicIterations = 16;
  localparam int IterW = 5;
  localparam logic signed [31:0] Deg90 = 32'sd5898240;
  localparam logic [2:0] ADDR_BIAS_X = 3'd0;
  localparam logic [2:0] ADDR_BIAS_Y = 3'd1;
  localparam logic [2:0] ADDR_BIAS_Z = 3'd2;
  localparam logic [2:0] ADDR_GAIN = 3'd3;
  localparam logic [2:0] ADDR_ALPHA = 3'd4;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
    logic [31:0] sample_index;
  } result_t;

  typedef struct packed {
    logic signed [15:0] bias_rate_x;
    logic signed [15:0] bias_rate_y;
    logic signed [15:0] bias_rate_z;
    logic [23:0] rate_gain;
    logic [16:0] blend_alpha;
  } cfg_t;

  // Start and done strobes between the sequencer and the CORDIC unit.
  typedef struct packed {
    logic start;
    logic done;
  } cordic_ctl_t;

  function automatic logic signed [31:0] atan_entry(input logic [IterW-1:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd2949120;  5'd1: r = 32'sd1740967; 5'd2: r = 32'sd919879;
      5'd3: r = 32'sd466945;   5'd4: r = 32'sd234379;  5'd5: r = 32'sd117304;
      5'd6: r = 32'sd58666;    5'd7: r = 32'sd29335;   5'd8: r = 32'sd14668;
      5'd9: r = 32'sd7334;     5'd10: r = 32'sd3667;   5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;     5'd13: r = 32'sd458;    5'd14: r = 32'sd229;
      5'd15: r = 32'sd115;     5'd16: r = 32'sd57;     5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;      5'd19: r = 32'sd7;      5'd20: r = 32'sd4;
      5'd21: r = 32'sd2;       5'd22: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

FILE: rtl/imu_caf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one sample or one result.
// ----------------------------------------------------------------------------
interface imu_caf_in_if (input logic clk);
  import imu_caf_pkg::*;
  logic valid;
  logic ready;
  sample_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface imu_caf_out_if (input logic clk);
  import imu_caf_pkg::*;
  logic valid;
  logic ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/imu_caf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for biases, rate gain and blend weight.
// ----------------------------------------------------------------------------
module imu_caf_cfg (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output imu_caf_pkg::cfg_t cfg
);
  import imu_caf_pkg::*;
  logic [2:0] idx;
  logic wr;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bias_rate_x <= '0;
      cfg.bias_rate_y <= '0;
      cfg.bias_rate_z <= '0;
      cfg.rate_gain <= 24'd300648;
      cfg.blend_alpha <= 17'd62915;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        ADDR_BIAS_X: cfg.bias_rate_x <= pwdata[15:0];
        ADDR_BIAS_Y: cfg.bias_rate_y <= pwdata[15:0];
        ADDR_BIAS_Z: cfg.bias_rate_z <= pwdata[15:0];
        ADDR_GAIN: cfg.rate_gain <= pwdata[23:0];
        ADDR_ALPHA: cfg.blend_alpha <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      ADDR_BIAS_X: prdata = {{16{cfg.bias_rate_x[15]}}, cfg.bias_rate_x};
      ADDR_BIAS_Y: prdata = {{16{cfg.bias_rate_y[15]}}, cfg.bias_rate_y};
      ADDR_BIAS_Z: prdata = {{16{cfg.bias_rate_z[15]}}, cfg.bias_rate_z};
      ADDR_GAIN: prdata = {8'd0, cfg.rate_gain};
      ADDR_ALPHA: prdata = {15'd0, cfg.blend_alpha};
      default: prdata = '0;
    endcase
  end
endmodule

FILE: rtl/imu_caf_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC arctangent unit
// Vectoring-mode atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`include "imu_complementary_attitude_filter_unit_macros.svh"
module imu_caf_cordic (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [16:0] y_in,
  input  logic signed [16:0] x_in,
  output logic done,
  output logic signed [31:0] angle
);
  import imu_caf_pkg::*;
  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cst_t;
  cst_t state;
  logic signed [33:0] x, y;
  logic [IterW-1:0] iter;
  logic signed [33:0] xs, ys;

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign done = (state == C_DONE);

  // Sequencer and rotation registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      iter <= '0;
    end else begin
      case (state)
        C_IDLE: if (start) begin
          iter <= '0;
          if (x_in == 0 && y_in == 0) begin
            angle <= '0;
            x <= '0;
            y <= '0;
            state <= C_DONE;
          end else begin
            // Pre-rotate left-half vectors by a quarter turn.
            if (x_in < 0) begin
              if (y_in >= 0) begin
                x <= 34'(y_in) <<< 12; y <= -(34'(x_in) <<< 12); angle <= Deg90;
              end else begin
                x <= -(34'(y_in) <<< 12); y <= 34'(x_in) <<< 12; angle <= -Deg90;
              end
            end else begin
              x <= 34'(x_in) <<< 12; y <= 34'(y_in) <<< 12; angle <= '0;
            end
            state <= C_RUN;
          end
        end
        C_RUN: begin
          if (y >= 0) begin
            x <= x + ys; y <= y - xs; angle <= angle + atan_entry(iter);
          end else begin
            x <= x - ys; y <= y + xs; angle <= angle - atan_entry(iter);
          end
          iter <= iter + 1'b1;
          if (iter == IterW'(CordicIterations - 1)) state <= C_DONE;
        end
        C_DONE: state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  `IMU_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `IMU_ASSERT_IMPL(a_iter_range, clk, rst, state == C_RUN, iter < IterW'(CordicIterations))
  `IMU_ASSERT_NEXT(a_run_exit, clk, rst, state == C_RUN && iter == IterW'(CordicIterations - 1),
                   done)
endmodule

FILE: rtl/imu_caf_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter sequencer
// Integrates rates, runs square root and CORDIC, blends and saturates.
// ----------------------------------------------------------------------------
`include "imu_complementary_attitude_filter_unit_macros.svh"
module imu_caf_core (
  input  logic clk,
  input  logic rst,
  input  imu_caf_pkg::cfg_t cfg,
  imu_caf_in_if.sink in_ch,
  imu_caf_out_if.source out_ch
);
  import imu_caf_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_INT, S_SQ, S_SQRT, S_ROLL, S_WROLL, S_PITCH, S_WPITCH, S_BL0, S_BL1,
    S_BL2, S_BL3, S_OUT
  } st_t;
  st_t state;
  sample_t smp;
  logic signed [31:0] roll_angle, pitch_angle, yaw_angle;
  logic [31:0] sample_counter;
  logic signed [31:0] g_roll, g_pitch, acc_roll, acc_pitch;
  logic [1:0] axis;
  // Square root registers.
  logic [31:0] sq_n, sq_root, sq_bit;
  logic [31:0] mag;
  // Shared multiplier.
  logic signed [32:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [66:0] prod;
  logic signed [49:0] acc_sum;
  logic signed [66:0] blend_sum;
  logic signed [66:0] blend_sum_reg;
  logic [16:0] alpha;
  cordic_ctl_t cc;
  logic signed [16:0] cy, cx;
  logic signed [31:0] cangle;

  assign alpha = (cfg.blend_alpha > 17'd65536) ? 17'd65536 : cfg.blend_alpha;
  assign prod = 67'(mul_a) * 67'(mul_b);
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.payload = '{roll_angle, pitch_angle, yaw_angle, sample_counter};
  assign cc.start = (state == S_ROLL) || (state == S_PITCH);
  assign cy = (state == S_ROLL) ? 17'(smp.accel_y) : -17'(smp.accel_x);
  assign cx = (state == S_ROLL) ? 17'(smp.accel_z) : {1'b0, mag[15:0]};

  imu_caf_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cc.start), .y_in(cy), .x_in(cx),
    .done(cc.done), .angle(cangle)
  );

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_INT: begin
        case (axis)
          2'd0: mul_a = 33'(smp.rate_x) - 33'(cfg.bias_rate_x);
          2'd1: mul_a = 33'(smp.rate_y) - 33'(cfg.bias_rate_y);
          default: mul_a = 33'(smp.rate_z) - 33'(cfg.bias_rate_z);
        endcase
        mul_b = 34'({1'b0, cfg.rate_gain});
      end
      S_SQ: begin
        mul_a = (axis == 2'd0) ? 33'(smp.accel_y) : 33'(smp.accel_z);
        mul_b = (axis == 2'd0) ? 34'(smp.accel_y) : 34'(smp.accel_z);
      end
      S_BL0: begin mul_a = 33'({16'd0, alpha}); mul_b = 34'(g_roll); end
      S_BL1: begin mul_a = 33'(17'd65536 - alpha) + 33'sd0; mul_b = 34'(acc_roll); end
      S_BL2: begin mul_a = 33'({16'd0, alpha}); mul_b = 34'(g_pitch); end
      S_BL3: begin mul_a = 33'({16'd0, 17'd65536 - alpha}); mul_b = 34'(acc_pitch); end
      default: ;
    endcase
  end

  assign acc_sum = 50'(prod[49:0]) + 50'sd32768;
  assign blend_sum = blend_sum_reg + prod;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      roll_angle <= '0;
      pitch_angle <= '0;
      yaw_angle <= '0;
      sample_counter <= '0;
      axis <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          smp <= in_ch.payload;
          sample_counter <= sample_counter + 32'd1;
          axis <= '0;
          state <= S_INT;
        end
        S_INT: begin
          // Round the increment to Q16.16 and add with saturation.
          case (axis)
            2'd0: g_roll <= sat32(50'(roll_angle) + (acc_sum >>> 16));
            2'd1: g_pitch <= sat32(50'(pitch_angle) + (acc_sum >>> 16));
            default: yaw_angle <= sat32(50'(yaw_angle) + (acc_sum >>> 16));
          endcase
          axis <= axis + 2'd1;
          if (axis == 2'd2) begin
            axis <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (axis == 2'd0) begin
            sq_n <= prod[31:0];
            axis <= 2'd1;
          end else begin
            sq_n <= sq_n + prod[31:0];
            sq_root <= '0;
            sq_bit <= 32'h4000_0000;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          // One result bit per cycle, restoring form.
          if (sq_bit == 0) begin
            mag <= sq_root;
            state <= S_ROLL;
          end else begin
            if (sq_n >= sq_root + sq_bit) begin
              sq_n <= sq_n - (sq_root + sq_bit);
              sq_root <= (sq_root >> 1) + sq_bit;
            end else begin
              sq_root <= sq_root >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_ROLL: state <= S_WROLL;
        S_WROLL: if (cc.done) begin
          acc_roll <= cangle;
          state <= S_PITCH;
        end
        S_PITCH: state <= S_WPITCH;
        S_WPITCH: if (cc.done) begin
          acc_pitch <= cangle;
          state <= S_BL0;
        end
        S_BL0: begin blend_sum_reg <= prod + 67'sd32768; state <= S_BL1; end
        S_BL1: begin
          roll_angle <= sat32(50'(blend_sum >>> 16));
          state <= S_BL2;
        end
        S_BL2: begin blend_sum_reg <= prod + 67'sd32768; state <= S_BL3; end
        S_BL3: begin
          pitch_angle <= sat32(50'(blend_sum >>> 16));
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `IMU_ASSERT_IMPL(a_no_overlap, clk, rst, in_ch.ready, !out_ch.valid)
  `IMU_ASSERT_NEXT(a_cnt_inc, clk, rst, in_ch.valid && in_ch.ready,
                   sample_counter == $past(sample_counter) + 32'd1)
  `IMU_ASSERT_NEXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

FILE: rtl/imu_complementary_attitude_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU complementary attitude filter
// Roll, pitch and yaw estimation from raw six-axis samples.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// in_ch     in   one raw six-axis sample request
// out_ch    out  roll, pitch, yaw and sample index
// apb       in   bias, gain and blend registers
//
// An item passes from one accepted request to the next through three
// integrate steps, two squaring steps, the square-root steps, two CORDIC
// passes of a start state and a busy wait each on the one shared
// rotation unit, four blend steps, the result state and the idle state.
// A zero vector skips the 16 rotations of its pass.
// Reset (rst, synchronous) clears the angles and the sample counter.
// The input is not ready while a sample is in work or its result waits.
module imu_complementary_attitude_filter_unit (
  input  logic clk,
  input  logic rst,
  imu_caf_in_if.sink in_ch,
  imu_caf_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import imu_caf_pkg::*;
  cfg_t cfg;

  imu_caf_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  imu_caf_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule
